// ----- rtl/dictionary_line_code_indexer_assert.svh -----
// Assertion macros for the dictionary line code indexer.
`ifndef DICTIONARY_LINE_CODE_INDEXER_ASSERT_SVH
`define DICTIONARY_LINE_CODE_INDEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define DLCI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlci assertion failed");
`define DLCI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlci assertion failed");
`else
`define DLCI_ASSERT_IMP(label, ante, cons)
`define DLCI_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/dlci_pkg.sv -----
// Shared types and constants of the dictionary line code indexer.
`default_nettype none
package dlci_pkg;

  localparam int CODE_SLOT_BYTES_DEF = 8;
  localparam int OUTQ_DEPTH          = 4;
  localparam int CODE_W              = 56;
  localparam int OFS_W               = 32;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  typedef enum logic [1:0] {
    ST_ENTRY    = 2'd0,
    ST_NO_ENTRY = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] entry_code;
    logic [OFS_W-1:0]  range_start;
    logic [OFS_W-1:0]  range_end;
    logic [OFS_W-1:0]  entry_number;
    status_t           result_status;
    logic              last_result;
  } result_t;

  // up to two results from one item: a closed range, then the closing result
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage
`default_nettype wire

// ----- rtl/dlci_scan.sv -----
// Line parser, range merger and closing logic, one item per cycle while acc is high.
`default_nettype none
`include "dictionary_line_code_indexer_assert.svh"
module dlci_scan #(
  parameter int CODE_SLOT_BYTES = dlci_pkg::CODE_SLOT_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [7:0]    data_byte,
  input  wire logic          final_byte,
  output dlci_pkg::push_t    push
);
  import dlci_pkg::*;

  localparam int LW   = 8 * (CODE_SLOT_BYTES - 1);
  localparam int LENW = $clog2(CODE_SLOT_BYTES);

  typedef enum logic [1:0] {PH_PRE, PH_CODE, PH_POST} phase_t;

  logic [OFS_W-1:0] pos_r, lstart_r, pstart_r, pend_r, cnt_r;
  logic             ovf_r, excl_r, crf_r, ok_r, pp_r;
  phase_t           phase_r;
  logic [LW-1:0]    letters_r, pcode_r;
  logic [LENW-1:0]  len_r;

  logic [OFS_W-1:0] nxt, fin_end, cnt1, cnt2;
  logic             ovf, is_lf, is_cr, is_content, at_start, do_fin, line_ok, same, emit;

  logic [OFS_W-1:0] base_start;
  phase_t           base_phase, upd_phase, fl_phase;
  logic             base_excl, upd_excl, fl_excl, base_ok, upd_ok, fl_ok;
  logic [LW-1:0]    base_letters, upd_letters, fl_letters;
  logic [LENW-1:0]  base_len, upd_len, fl_len;
  logic [OFS_W-1:0] fl_start;

  logic [LW-1:0]    pcode_nxt;
  logic [OFS_W-1:0] pstart_nxt, pend_nxt;
  logic             pp_nxt;

  always_comb begin
    nxt        = pos_r + OFS_W'(1);
    ovf        = ovf_r | (&pos_r);
    is_lf      = data_byte == CH_LF;
    is_cr      = data_byte == CH_CR;
    is_content = !is_lf && !is_cr;

    // a pending CR finishes the line; the new line starts here
    if (crf_r) begin
      base_start   = pos_r;
      base_phase   = PH_PRE;
      base_excl    = 1'b0;
      base_letters = '0;
      base_len     = '0;
      base_ok      = 1'b1;
    end else begin
      base_start   = lstart_r;
      base_phase   = phase_r;
      base_excl    = excl_r;
      base_letters = letters_r;
      base_len     = len_r;
      base_ok      = ok_r;
    end
    at_start = crf_r | (pos_r == lstart_r);

    upd_phase   = base_phase;
    upd_excl    = base_excl;
    upd_letters = base_letters;
    upd_len     = base_len;
    upd_ok      = base_ok;
    if (is_content) begin
      if (at_start && (data_byte == CH_HASH || data_byte == CH_TAB)) upd_excl = 1'b1;
      case (base_phase)
        PH_PRE: begin
          if (data_byte == CH_TAB) begin
            upd_phase   = PH_CODE;
            upd_letters = '0;
            upd_len     = '0;
            upd_ok      = 1'b1;
          end
        end
        PH_CODE: begin
          if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
            upd_phase = PH_POST;
          end else if (data_byte < CH_LOW_A || data_byte > CH_LOW_Z) begin
            upd_ok = 1'b0;
          end else if (base_len == LENW'(CODE_SLOT_BYTES - 1)) begin
            upd_ok = 1'b0;
          end else begin
            for (int i = 0; i < CODE_SLOT_BYTES - 1; i++) begin
              if (base_len == LENW'(i)) upd_letters[8*i +: 8] = data_byte;
            end
            upd_len = base_len + LENW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (crf_r) begin
      fl_start   = lstart_r;
      fl_phase   = phase_r;
      fl_excl    = excl_r;
      fl_letters = letters_r;
      fl_len     = len_r;
      fl_ok      = ok_r;
      fin_end    = is_lf ? nxt : pos_r;
    end else begin
      fl_start   = base_start;
      fl_phase   = upd_phase;
      fl_excl    = upd_excl;
      fl_letters = upd_letters;
      fl_len     = upd_len;
      fl_ok      = upd_ok;
      fin_end    = nxt;
    end

    do_fin  = crf_r | is_lf | final_byte;
    line_ok = do_fin && !fl_excl && fl_phase != PH_PRE && fl_len != '0 && fl_ok;
    same    = pp_r && pcode_r == fl_letters;
    emit    = line_ok && pp_r && !same && !ovf;
    cnt1    = cnt_r + OFS_W'(emit);

    pcode_nxt  = pcode_r;
    pstart_nxt = pstart_r;
    pend_nxt   = pend_r;
    pp_nxt     = pp_r;
    if (line_ok) begin
      pend_nxt = fin_end;
      if (!same) begin
        pcode_nxt  = fl_letters;
        pstart_nxt = fl_start;
        pp_nxt     = 1'b1;
      end
    end
    cnt2 = cnt1 + OFS_W'(final_byte && !ovf && pp_nxt);

    push.v0                 = acc && emit;
    push.r0.entry_code      = CODE_W'(pcode_r);
    push.r0.range_start     = pstart_r;
    push.r0.range_end       = pend_r;
    push.r0.entry_number    = cnt1;
    push.r0.result_status   = ST_ENTRY;
    push.r0.last_result     = 1'b0;

    push.v1                 = acc && final_byte;
    push.r1.last_result     = 1'b1;
    push.r1.entry_number    = cnt2;
    if (ovf) begin
      push.r1.entry_code    = '0;
      push.r1.range_start   = '0;
      push.r1.range_end     = '0;
      push.r1.result_status = ST_OVERFLOW;
    end else if (pp_nxt) begin
      push.r1.entry_code    = CODE_W'(pcode_nxt);
      push.r1.range_start   = pstart_nxt;
      push.r1.range_end     = pend_nxt;
      push.r1.result_status = ST_ENTRY;
    end else begin
      push.r1.entry_code    = '0;
      push.r1.range_start   = '0;
      push.r1.range_end     = '0;
      push.r1.result_status = ST_NO_ENTRY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && final_byte)) begin
      pos_r     <= '0;
      ovf_r     <= 1'b0;
      crf_r     <= 1'b0;
      lstart_r  <= '0;
      phase_r   <= PH_PRE;
      excl_r    <= 1'b0;
      letters_r <= '0;
      len_r     <= '0;
      ok_r      <= 1'b1;
      pcode_r   <= '0;
      pstart_r  <= '0;
      pend_r    <= '0;
      pp_r      <= 1'b0;
      cnt_r     <= '0;
    end else if (acc) begin
      pos_r    <= nxt;
      ovf_r    <= ovf;
      crf_r    <= is_cr;
      pcode_r  <= pcode_nxt;
      pstart_r <= pstart_nxt;
      pend_r   <= pend_nxt;
      pp_r     <= pp_nxt;
      cnt_r    <= cnt1;
      if (is_lf) begin
        lstart_r  <= nxt;
        phase_r   <= PH_PRE;
        excl_r    <= 1'b0;
        letters_r <= '0;
        len_r     <= '0;
        ok_r      <= 1'b1;
      end else begin
        lstart_r  <= base_start;
        phase_r   <= upd_phase;
        excl_r    <= upd_excl;
        letters_r <= upd_letters;
        len_r     <= upd_len;
        ok_r      <= upd_ok;
      end
    end
  end

  `DLCI_ASSERT_NXT(a_restart, acc && final_byte, pos_r == '0 && !pp_r && cnt_r == '0)
  `DLCI_ASSERT_NXT(a_count_step, acc && !final_byte && emit, cnt_r == $past(cnt_r) + OFS_W'(1))
  `DLCI_ASSERT_IMP(a_no_emit_ovf, emit, !ovf_r && !(&pos_r))

endmodule
`default_nettype wire

// ----- rtl/dlci_outq.sv -----
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
`default_nettype none
`include "dictionary_line_code_indexer_assert.svh"
module dlci_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dlci_pkg::push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dlci_pkg::result_t      head
);
  import dlci_pkg::*;

  localparam int PTRW = $clog2(OUTQ_DEPTH);
  localparam int CW   = $clog2(OUTQ_DEPTH + 1);

  result_t         mem_r [OUTQ_DEPTH];
  logic [PTRW-1:0] wp_r, rp_r, wp1;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  assign wp1       = wp_r + PTRW'(push.v0);
  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign room      = cnt_r <= CW'(OUTQ_DEPTH - 2);
  assign head      = mem_r[rp_r];
  assign cnt_nxt   = cnt_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wp_r] <= push.r0;
    if (push.v1) mem_r[wp1]  <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp1 + PTRW'(push.v1);
      rp_r  <= rp_r + PTRW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  `DLCI_ASSERT_IMP(a_push_room, push.v0 || push.v1, cnt_r <= CW'(OUTQ_DEPTH - 2))
  `DLCI_ASSERT_NXT(a_pop_only, pop && !push.v0 && !push.v1, cnt_r == $past(cnt_r) - CW'(1))

endmodule
`default_nettype wire

// ----- rtl/dictionary_line_code_indexer.sv -----
// Top level of the dictionary line code indexer.
// Throughput: one byte item per cycle; in_tready drops only while the result
// queue (four entries) holds more than two items.
// Results of a byte enter the queue at its accepting edge and can show on the
// output in the next cycle at the earliest; a final byte can add two.
// Reset (rst_n low, synchronous) clears parser, pending range and queue at once.
`default_nettype none
module dictionary_line_code_indexer #(
  parameter int CODE_SLOT_BYTES = dlci_pkg::CODE_SLOT_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tlast,   // final_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [151:0]      out_tdata,  // entry_code, range_start, range_end, entry_number
  output logic [1:0]        out_tuser,  // result_status
  output logic              out_tlast   // last_result
);
  import dlci_pkg::*;

  logic    acc;
  push_t   push;
  result_t head;

  assign acc = in_tvalid && in_tready;

  dlci_scan #(.CODE_SLOT_BYTES(CODE_SLOT_BYTES)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .push       (push)
  );

  dlci_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {head.entry_number, head.range_end, head.range_start, head.entry_code};
  assign out_tuser = head.result_status;
  assign out_tlast = head.last_result;

endmodule
`default_nettype wire

// ----- bench/dictionary_line_code_indexer_tb.sv -----
// Self-checking bench for the dictionary line code indexer: byte streams in, merged ranges out.
`timescale 1ns / 100ps
module dictionary_line_code_indexer_tb;
  import dlci_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CODE_MAX    = CODE_SLOT_BYTES_DEF - 1;

  class line_range_board;
    typedef enum bit [1:0] {SEEK_TAB, IN_CODE, PAST_CODE} line_phase_t;

    bit [31:0]         pos;
    bit                ovf;
    bit [31:0]         lstart;
    line_phase_t       phase;
    bit                excl;
    bit                cr_seen;
    bit [CODE_W-1:0]   letters;
    int unsigned       clen;
    bit                cok;
    bit [CODE_W-1:0]   pcode;
    bit [31:0]         pstart;
    bit [31:0]         pend;
    bit                ppres;
    bit [31:0]         count;
    result_t           ranges_due[$];
    int                errors;
    int                checked;

    function new();
      errors  = 0;
      checked = 0;
      clear_all();
    endfunction

    function void restart_line(bit [31:0] nxt);
      lstart  = nxt;
      phase   = SEEK_TAB;
      excl    = 1'b0;
      letters = '0;
      clen    = 0;
      cok     = 1'b1;
    endfunction

    function void clear_all();
      pos     = '0;
      ovf     = 1'b0;
      cr_seen = 1'b0;
      restart_line('0);
      pcode   = '0;
      pstart  = '0;
      pend    = '0;
      ppres   = 1'b0;
      count   = '0;
    endfunction

    function void add_due(bit [CODE_W-1:0] code, bit [31:0] s, bit [31:0] e,
                          status_t st, bit last);
      result_t r;
      r.entry_code    = code;
      r.range_start   = s;
      r.range_end     = e;
      r.entry_number  = count;
      r.result_status = st;
      r.last_result   = last;
      ranges_due.push_back(r);
    endfunction

    function void close_line(bit [31:0] e);
      bit valid;
      valid = !excl && phase != SEEK_TAB && clen >= 1 && cok;
      if (valid) begin
        if (ppres && pcode == letters) begin
          pend = e;
        end else begin
          if (ppres && !ovf) begin
            count++;
            add_due(pcode, pstart, pend, ST_ENTRY, 1'b0);
          end
          pcode  = letters;
          pstart = lstart;
          pend   = e;
          ppres  = 1'b1;
        end
      end
      restart_line(e);
    endfunction

    function void take_byte(bit [31:0] p, bit [7:0] b);
      if (p == lstart && (b == CH_HASH || b == CH_TAB)) excl = 1'b1;
      case (phase)
        SEEK_TAB: begin
          if (b == CH_TAB) begin
            phase   = IN_CODE;
            letters = '0;
            clen    = 0;
            cok     = 1'b1;
          end
        end
        IN_CODE: begin
          if (b == CH_SPACE || b == CH_TAB) phase = PAST_CODE;
          else if (b < CH_LOW_A || b > CH_LOW_Z) cok = 1'b0;
          else if (clen >= CODE_MAX) cok = 1'b0;
          else begin
            letters[clen*8 +: 8] = b;
            clen++;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_input(bit [7:0] b, bit fin);
      bit [31:0] p;
      bit [31:0] nxt;
      bit        eaten;
      p     = pos;
      nxt   = pos + 32'd1;
      eaten = 1'b0;
      if (p == 32'hFFFF_FFFF) ovf = 1'b1;
      if (cr_seen) begin
        cr_seen = 1'b0;
        if (b == CH_LF) begin
          close_line(nxt);
          eaten = 1'b1;
        end else begin
          close_line(p);
        end
      end
      if (!eaten) begin
        if (b == CH_LF) close_line(nxt);
        else if (b == CH_CR) begin
          if (fin) close_line(nxt);
          else cr_seen = 1'b1;
        end else begin
          take_byte(p, b);
          if (fin) close_line(nxt);
        end
      end
      pos = nxt;
      if (fin) begin
        if (ovf) add_due('0, '0, '0, ST_OVERFLOW, 1'b1);
        else if (ppres) begin
          count++;
          add_due(pcode, pstart, pend, ST_ENTRY, 1'b1);
        end else add_due('0, '0, '0, ST_NO_ENTRY, 1'b1);
        clear_all();
      end
    endfunction

    function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [151:0] d, logic [1:0] u, logic l);
      result_t x;
      checked++;
      if (ranges_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %h status %h last %b",
                 $time, d, u, l);
        return;
      end
      x = ranges_due.pop_front();
      cmp_field("entry_code", x.entry_code, d[55:0]);
      cmp_field("range_start", x.range_start, d[87:56]);
      cmp_field("range_end", x.range_end, d[119:88]);
      cmp_field("entry_number", x.entry_number, d[151:120]);
      cmp_field("result_status", x.result_status, u);
      cmp_field("last_result", x.last_result, l);
    endfunction
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  line_range_board board = new();
  bit [8:0]        text_q[$];
  string           code_pool[6] = '{"a", "ab", "zz", "abcdefg", "abcdefgh", "q"};
  int              pool_pick  = 0;
  int              tx_idle_pct  = 0;
  int              rx_stall_pct = 0;
  bit              rx_hold    = 1'b0;
  int              bytes_sent = 0;
  int              files_sent = 0;
  int              cycle_cnt  = 0;

  dictionary_line_code_indexer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dictionary_line_code_indexer_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
  end

  task automatic hold_off(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // called just after a rising edge; returns at the edge that took the item
  task automatic send_byte(bit [7:0] b, bit fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    board.note_input(b, fin);
    bytes_sent++;
  endtask

  task automatic play_file();
    foreach (text_q[i]) send_byte(text_q[i][7:0], text_q[i][8]);
    files_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.ranges_due.size() != 0) @(posedge clk);
  endtask

  function automatic void put(bit [7:0] b);
    text_q.push_back({1'b0, b});
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void mark_final();
    text_q[text_q.size()-1][8] = 1'b1;
  endfunction

  function automatic bit [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic void add_line();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      put(CH_HASH);
      put(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
    end else if (r < 18) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) put(printable());
      if (r >= 14) begin
        put(CH_LF);
        return;
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) put(printable());
    end
    put(CH_TAB);
    if ($urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 99) >= 40) pool_pick = $urandom_range(0, 5);
      put_str(code_pool[pool_pick]);
    end else begin
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 85) put(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
        else put(8'($urandom_range(0, 255)));
      end
    end
    case ($urandom_range(0, 2))
      1: put(CH_SPACE);
      2: put(CH_TAB);
      default: ;
    endcase
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) put($urandom_range(0, 4) == 0 ? CH_TAB : printable());
    case ($urandom_range(0, 3))
      2: begin
        put(CH_CR);
        put(CH_LF);
      end
      3: put(CH_CR);
      default: put(CH_LF);
    endcase
  endfunction

  function automatic void make_file();
    int lines;
    int n;
    text_q.delete();
    if ($urandom_range(0, 99) < 4) begin
      put(8'($urandom_range(0, 255)));
    end else begin
      lines = $urandom_range(1, 12);
      for (int k = 0; k < lines; k++) begin
        if ($urandom_range(0, 99) < 6) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
        end else add_line();
      end
      case ($urandom_range(0, 2))
        1: put(printable());
        2: put(CH_LF);
        default: ;
      endcase
    end
    mark_final();
  endfunction

  task automatic random_phase(int idle, int stall, int nbytes);
    int target;
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    target       = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      make_file();
      play_file();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hash line, leading tab, CR then content, CRLF merge, CR as final byte
    text_q.delete();
    put_str("#\ta\n\tb\nk\tab c\rk\tab\r\nk\tz\r");
    mark_final();
    play_file();
    // file without any entry
    text_q.delete();
    put(CH_LF);
    mark_final();
    play_file();
    drain();

    random_phase(0, 0, 300);
    random_phase(68, 0, 300);
    random_phase(0, 68, 300);
    random_phase(30, 30, 300);

    // receiver held off while short lines with alternating codes keep coming
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    text_q.delete();
    for (int k = 0; k < 40; k++) put_str(k % 2 ? "p\tab\n" : "p\tcd\n");
    mark_final();
    fork
      hold_off(150);
    join_none
    play_file();
    drain();

    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d files; checked %0d results.",
             bytes_sent, files_sent, board.checked);
    $display("Idle phases: none, sender gaps, receiver stalls, both; plus a long receiver hold.");
    if (board.errors == 0 && board.ranges_due.size() == 0) begin
      $display("dictionary_line_code_indexer_tb OK");
    end else begin
      $display("dictionary_line_code_indexer_tb NOT OK");
    end
    $finish;
  end

endmodule
